// ----- rtl/mqpd_pkg.sv -----
// package for the priority deque bank: field widths, default sizes and result codes
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package mqpd_pkg;

	localparam int DEF_NUM_QUEUES  = 16;
	localparam int DEF_QUEUE_DEPTH = 8;
	localparam int DEF_TAG_BITS    = 16;

	// port field widths
	localparam int QSEL_BITS     = 4;
	localparam int PORT_TAG_BITS = 16;
	localparam int FILL_BITS     = 4;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TAKE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RES_ADDED = 2'd0,
		RES_FULL  = 2'd1,
		RES_TAKEN = 2'd2,
		RES_EMPTY = 2'd3
	} result_code_t;

endpackage

`default_nettype wire

// ----- rtl/mqpd_req_if.sv -----
// request channel of the priority deque bank: valid/ready plus operation payload
// depends on mqpd_pkg
`default_nettype none

interface mqpd_req_if import mqpd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	op_t                  operation;
	logic [QSEL_BITS-1:0] queue_select;
	logic [PORT_TAG_BITS-1:0] item_tag;
	logic                 urgent;

	modport source (output valid, output operation, output queue_select,
		output item_tag, output urgent, input ready);
	modport sink (input valid, input operation, input queue_select,
		input item_tag, input urgent, output ready);
endinterface

`default_nettype wire

// ----- rtl/mqpd_rsp_if.sv -----
// response channel of the priority deque bank: valid/ready plus result payload
// depends on mqpd_pkg
`default_nettype none

interface mqpd_rsp_if import mqpd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	result_code_t             result_code;
	logic [PORT_TAG_BITS-1:0] taken_tag;
	logic                     taken_urgent;
	logic [FILL_BITS-1:0]     queue_fill;

	modport source (output valid, output result_code, output taken_tag,
		output taken_urgent, output queue_fill, input ready);
	modport sink (input valid, input result_code, input taken_tag,
		input taken_urgent, input queue_fill, output ready);
endinterface

`default_nettype wire

// ----- rtl/mqpd_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; read data holds while no read is issued
`default_nettype none

module mqpd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/multi_queue_priority_deque_top.sv -----
// Bank of NUM_QUEUES bounded deques with front insertion for urgent items.
// req channel (sink): operation add or take, queue_select, item_tag, urgent.
// rsp channel (source): result_code, taken_tag, taken_urgent, queue_fill.
// Exactly one response per request, in request order.
// An add to a full queue is rejected; a regular add goes to the back, an urgent
// add to the front. A take pops the front or reports the queue empty.
// queue_select wraps modulo NUM_QUEUES.
// Throughput: one transaction per cycle while rsp does not stall. Head pointers
// and lengths sit in flops, entries in one ram, so every operation needs at
// most a single ram access. A response passes the ram read stage and then the
// output register before it is valid.
// Reset empties all queues at once; entry contents are never cleared since a
// take only reads slots that an add has written.
// When rsp stalls, one further request is taken into the read stage and then
// req.ready drops until the output register frees.
// Depends on mqpd_pkg, mqpd_req_if, mqpd_rsp_if, mqpd_ram.
`default_nettype none

module multi_queue_priority_deque_top import mqpd_pkg::*; #(
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TAG_BITS    = DEF_TAG_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mqpd_req_if.sink  req,
	mqpd_rsp_if.source rsp
);

	localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int LW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int WW    = TAG_BITS + 1;
	localparam int NSEL  = 2 ** QSEL_BITS;

	// queue select wrap table
	logic [QW-1:0] wrap_tbl [NSEL];
	for (genvar g = 0; g < NSEL; g++) begin : g_wrap
		localparam int WRAPPED = g % NUM_QUEUES;
		assign wrap_tbl[g] = QW'(WRAPPED);
	end

	logic [HW-1:0] head_q [NUM_QUEUES];
	logic [LW-1:0] len_q  [NUM_QUEUES];

	logic [QW-1:0]   q_idx;
	logic [HW-1:0]   cur_head;
	logic [LW-1:0]   cur_len;
	logic            is_full;
	logic            is_empty;
	logic            accept;
	logic            add_ok;
	logic            take_ok;
	logic [HW-1:0]   head_dec;
	logic [HW-1:0]   head_inc;
	logic [HW:0]     tail_sum;
	logic [HW-1:0]   tail_pos;
	logic [HW-1:0]   wr_pos;
	logic [AW-1:0]   base_addr;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;
	logic [LW-1:0]   next_len;
	result_code_t    code;
	logic [TAG_BITS+PORT_TAG_BITS-1:0] tag_in_ext;
	logic [WW-1:0]   wr_data;
	logic [WW-1:0]   rd_data;
	logic [TAG_BITS+PORT_TAG_BITS-1:0] tag_out_ext;
	logic [LW+FILL_BITS-1:0] fill_ext;
	logic            out_free;

	logic            valid_s1;
	result_code_t    code_s1;
	logic [FILL_BITS-1:0] fill_s1;

	logic            out_valid_q;
	result_code_t    code_q;
	logic [PORT_TAG_BITS-1:0] tag_q;
	logic            urg_q;
	logic [FILL_BITS-1:0] fill_q;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || out_free;
	assign accept    = req.valid && req.ready;

	assign q_idx    = wrap_tbl[req.queue_select];
	assign cur_head = head_q[q_idx];
	assign cur_len  = len_q[q_idx];
	assign is_full  = (cur_len == LW'(QUEUE_DEPTH));
	assign is_empty = (cur_len == '0);
	assign add_ok   = (req.operation == OP_ADD) && !is_full;
	assign take_ok  = (req.operation == OP_TAKE) && !is_empty;

	assign head_dec = (cur_head == '0) ? HW'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
	assign head_inc = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
	// head + length stays below twice the depth, one subtract wraps it
	assign tail_sum = {1'b0, cur_head} + (HW+1)'(cur_len);
	assign tail_pos = (tail_sum >= (HW+1)'(QUEUE_DEPTH))
		? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
	assign wr_pos   = req.urgent ? head_dec : tail_pos;

	assign base_addr = AW'(q_idx * QUEUE_DEPTH);
	assign wr_addr   = base_addr + AW'(wr_pos);
	assign rd_addr   = base_addr + AW'(cur_head);

	assign tag_in_ext = {{TAG_BITS{1'b0}}, req.item_tag};
	assign wr_data    = {req.urgent, tag_in_ext[TAG_BITS-1:0]};

	always_comb begin
		next_len = cur_len;
		code     = RES_FULL;
		unique case (req.operation)
			OP_ADD: begin
				if (is_full) begin
					code = RES_FULL;
				end else begin
					code     = RES_ADDED;
					next_len = cur_len + 1'b1;
				end
			end
			OP_TAKE: begin
				if (is_empty) begin
					code = RES_EMPTY;
				end else begin
					code     = RES_TAKEN;
					next_len = cur_len - 1'b1;
				end
			end
			default: begin
				code = RES_FULL;
			end
		endcase
	end

	assign fill_ext = {{FILL_BITS{1'b0}}, next_len};

	mqpd_ram #(
		.WIDTH(WW),
		.DEPTH(SLOTS)
	) u_entries (
		.clk  (clk),
		.we   (accept && add_ok),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (accept && take_ok),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign tag_out_ext = {{PORT_TAG_BITS{1'b0}}, rd_data[TAG_BITS-1:0]};

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else if (accept) begin
			len_q[q_idx] <= next_len;
			if (add_ok && req.urgent) begin
				head_q[q_idx] <= head_dec;
			end else if (take_ok) begin
				head_q[q_idx] <= head_inc;
			end
		end
	end

	// read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= code;
			fill_s1 <= fill_ext[FILL_BITS-1:0];
		end
		if (valid_s1 && out_free) begin
			code_q <= code_s1;
			fill_q <= fill_s1;
			if (code_s1 == RES_TAKEN) begin
				tag_q <= tag_out_ext[PORT_TAG_BITS-1:0];
				urg_q <= rd_data[WW-1];
			end else begin
				tag_q <= '0;
				urg_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_code  = code_q;
	assign rsp.taken_tag    = tag_q;
	assign rsp.taken_urgent = urg_q;
	assign rsp.queue_fill   = fill_q;

endmodule

`default_nettype wire
